/* design/erf_pkg.sv */
package erf_pkg;

    localparam int MAG_W         = 17;
    localparam int DEN_W         = 38;
    localparam int T_W           = 25;
    localparam int ACC_W         = 28;
    localparam int Q_W           = 26;
    localparam int E_W           = 25;
    localparam int DIV_STAGES    = 25;
    localparam int HORNER_STAGES = 5;
    localparam int EXP_BITS      = 16;

    localparam logic [22:0] P_Q24     = 23'd5496067;
    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [24:0] ONE_Q24   = 25'd16777216;
    localparam logic [23:0] HALF_Q24  = 24'd8388608;

    // One item as it moves down the pipeline; each part fills in its own fields.
    typedef struct packed {
        logic                    neg;
        logic [MAG_W-1:0]        mag;
        logic [DEN_W-1:0]        den;
        logic [T_W-1:0]          t;
        logic signed [ACC_W-1:0] acc;
        logic [Q_W-1:0]          q;
        logic [E_W-1:0]          e;
    } erf_item_t;

    // Polynomial coefficients a1..a5 in Q.24, indexed from 0.
    function automatic logic signed [ACC_W-1:0] coef_q24(input logic [2:0] k);
        logic signed [ACC_W-1:0] c;
        case (k)
            3'd0:    c = 28'sd4275331;
            3'd1:    c = -28'sd4773063;
            3'd2:    c = 28'sd23847365;
            3'd3:    c = -28'sd24379845;
            3'd4:    c = 28'sd17807428;
            default: c = '0;
        endcase
        return c;
    endfunction

    // 2^-(2^-(j+1)) in Q.24.
    function automatic logic [23:0] pow2_neg_q24(input logic [3:0] j);
        logic [23:0] c;
        case (j)
            4'd0:    c = 24'd11863283;
            4'd1:    c = 24'd14107901;
            4'd2:    c = 24'd15384775;
            4'd3:    c = 24'd16065917;
            4'd4:    c = 24'd16417715;
            4'd5:    c = 24'd16596492;
            4'd6:    c = 24'd16686451;
            4'd7:    c = 24'd16731773;
            4'd8:    c = 24'd16754518;
            4'd9:    c = 24'd16765863;
            4'd10:   c = 24'd16771538;
            4'd11:   c = 24'd16774377;
            4'd12:   c = 24'd16775796;
            4'd13:   c = 24'd16776506;
            4'd14:   c = 24'd16776861;
            default: c = 24'd16777039;
        endcase
        return c;
    endfunction

    // round(v * t / 2^24) with halves rounded away from zero.
    function automatic logic signed [ACC_W-1:0] mul_rnd(input logic signed [ACC_W-1:0] v,
                                                        input logic [T_W-1:0] t);
        logic [ACC_W-1:0]     m;
        logic [ACC_W+T_W-1:0] p;
        logic [ACC_W-1:0]     r;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        p = (ACC_W+T_W)'(m) * (ACC_W+T_W)'(t) + (ACC_W+T_W)'(HALF_Q24);
        r = p[ACC_W+23:24];
        return v[ACC_W-1] ? -$signed(r) : $signed(r);
    endfunction

endpackage

/* design/error_function_approx.sv */
// Channel  | Direction | Payload
// ---------+-----------+------------------------------------------------------
// s_axis   | in        | tdata[15:0] = arg_x, signed Q4.12
// m_axis   | out       | tdata[15:0] = erf_value, signed Q1.14, within +-1.0
//
// The pipeline takes one item every cycle unless the output stalls. It has
// one input stage, 25 divider stages (one quotient bit each), five
// Horner multiply stages, 19 exponential stages and two output stages.
// Reset clears every valid bit; payload registers are not reset.
// All stages advance together while the output register is empty or being
// taken, so a stall freezes the whole pipeline and drops nothing.
module error_function_approx (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] arg_x
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] erf_value
);
    import erf_pkg::*;

    // Global advance: the output register can accept a new item.
    logic en;

    logic        m_vld_reg;
    logic [15:0] m_data_reg;

    assign en            = !m_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = m_data_reg;

    // Input stage: take the magnitude, keep the sign and form 1 + p*|x|
    // scaled to Q.36 as the divider's denominator.
    logic      in_neg;
    logic [MAG_W-1:0] in_mag;
    erf_item_t in_item;
    logic      pre_vld_reg;
    erf_item_t pre_item_reg;

    always_comb
    begin
        in_neg      = s_axis_tdata[15];
        in_mag      = in_neg ? (17'h10000 - {1'b0, s_axis_tdata}) : {1'b0, s_axis_tdata};
        in_item     = '0;
        in_item.neg = in_neg;
        in_item.mag = in_mag;
        in_item.den = {2'b01, 36'd0} + DEN_W'(P_Q24) * DEN_W'(in_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_vld_reg <= 1'b0;
        else if (en)
            pre_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pre_item_reg <= in_item;
    end

    // The divider yields t, Horner's rule yields q, then exp(-x^2) gives e.
    logic      div_vld;
    erf_item_t div_item;
    logic      hor_vld;
    erf_item_t hor_item;
    logic      exp_vld;
    erf_item_t exp_item;

    erf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (pre_vld_reg),
        .in_item  (pre_item_reg),
        .out_vld  (div_vld),
        .out_item (div_item)
    );

    erf_horner u_horner (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (div_vld),
        .in_item  (div_item),
        .out_vld  (hor_vld),
        .out_item (hor_item)
    );

    erf_exp u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (hor_vld),
        .in_item  (hor_item),
        .out_vld  (exp_vld),
        .out_item (exp_item)
    );

    // Product stage: q * e rounded back to Q.24.
    logic [50:0] prod_full;
    logic        prod_vld_reg;
    logic        prod_neg_reg;
    logic [26:0] prod_reg;

    assign prod_full = 51'(exp_item.q) * 51'(exp_item.e) + 51'(HALF_Q24);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else if (en)
            prod_vld_reg <= exp_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_neg_reg <= exp_item.neg;
            prod_reg     <= prod_full[50:24];
        end
    end

    // Output stage: 1 - product, round to Q1.14 half up, clamp, restore sign.
    logic [24:0] res_r;
    logic [15:0] res_mag;
    logic [15:0] m_data_next;

    always_comb
    begin
        res_r   = (prod_reg >= 27'(ONE_Q24)) ? '0 : 25'(27'(ONE_Q24) - prod_reg);
        res_mag = 16'((26'(res_r) + 26'd512) >> 10);
        if (res_mag > 16'd16384)
            res_mag = 16'd16384;
        m_data_next = prod_neg_reg ? (16'd0 - res_mag) : res_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= prod_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m_data_reg <= m_data_next;
    end

    // A delivered value never leaves the closed range -1.0 to +1.0.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= 16'sd16384 &&
                           $signed(m_axis_tdata) >= -16'sd16384))
        else $error("erf result outside +-1.0");

    // The first cycle after reset shows no result.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled output freezes the pipeline, so the input side must back off.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

endmodule

/* design/erf_div.sv */
module erf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  erf_pkg::erf_item_t in_item,
    output logic               out_vld,
    output erf_pkg::erf_item_t out_item
);
    import erf_pkg::*;

    // Restoring division, one quotient bit per stage: t = round(2^60 / den).
    logic             vld_reg  [DIV_STAGES];
    erf_item_t        item_reg [DIV_STAGES];
    logic [DEN_W-1:0] rem_reg  [DIV_STAGES];
    logic [T_W-1:0]   low_reg  [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        logic             src_vld;
        erf_item_t        src_item;
        logic [DEN_W-1:0] src_rem;
        logic [T_W-1:0]   src_low;
        logic [DEN_W:0]   rem_sh;
        logic             ge;
        erf_item_t        item_next;
        logic [DEN_W-1:0] rem_next;

        if (i == 0) begin : g_first
            // The numerator is 2^60 + den/2; its top bits seed the remainder.
            assign src_vld  = in_vld;
            assign src_item = in_item;
            assign src_rem  = {3'b001, 35'd0} + DEN_W'(in_item.den[DEN_W-1:26]);
            assign src_low  = in_item.den[25:1];
        end else begin : g_next
            assign src_vld  = vld_reg[i-1];
            assign src_item = item_reg[i-1];
            assign src_rem  = rem_reg[i-1];
            assign src_low  = low_reg[i-1];
        end

        assign rem_sh = {src_rem, src_low[T_W-1]};
        assign ge     = rem_sh >= {1'b0, src_item.den};

        always_comb
        begin
            item_next   = src_item;
            item_next.t = (i == 0) ? T_W'(ge) : {src_item.t[T_W-2:0], ge};
            rem_next    = ge ? DEN_W'(rem_sh - {1'b0, src_item.den}) : rem_sh[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[i] <= item_next;
                rem_reg[i]  <= rem_next;
                low_reg[i]  <= {src_low[T_W-2:0], 1'b0};
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_item = item_reg[DIV_STAGES-1];

endmodule

/* design/erf_horner.sv */
module erf_horner (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  erf_pkg::erf_item_t in_item,
    output logic               out_vld,
    output erf_pkg::erf_item_t out_item
);
    import erf_pkg::*;

    logic      vld_reg  [HORNER_STAGES];
    erf_item_t item_reg [HORNER_STAGES];

    for (genvar i = 0; i < HORNER_STAGES; i++) begin : g_stage
        logic                    src_vld;
        erf_item_t               src_item;
        logic signed [ACC_W-1:0] prod;
        erf_item_t               item_next;

        if (i == 0) begin : g_first
            always_comb
            begin
                src_item     = in_item;
                src_item.acc = coef_q24(3'd4);
            end
            assign src_vld = in_vld;
        end else begin : g_next
            assign src_vld  = vld_reg[i-1];
            assign src_item = item_reg[i-1];
        end

        assign prod = mul_rnd(src_item.acc, src_item.t);

        always_comb
        begin
            item_next = src_item;
            if (i < HORNER_STAGES - 1)
            begin
                item_next.acc = prod + coef_q24(3'(HORNER_STAGES - 2 - i));
            end
            else
            begin
                // Last step forms q; a negative value is forced to zero.
                item_next.acc = prod;
                item_next.q   = prod[ACC_W-1] ? '0 : Q_W'(prod);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                item_reg[i] <= item_next;
        end
    end

    assign out_vld  = vld_reg[HORNER_STAGES-1];
    assign out_item = item_reg[HORNER_STAGES-1];

endmodule

/* design/erf_exp.sv */
module erf_exp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  erf_pkg::erf_item_t in_item,
    output logic               out_vld,
    output erf_pkg::erf_item_t out_item
);
    import erf_pkg::*;

    // exp(-mag^2) as 2^-(mag^2 * log2 e): square, scale, sixteen table
    // factors for the fraction, then a rounding right shift by the integer part.
    logic        sq_vld_reg;
    erf_item_t   sq_item_reg;
    logic [30:0] sq_reg;

    logic        sc_vld_reg;
    erf_item_t   sc_item_reg;
    logic [6:0]  sc_n_reg;
    logic [15:0] sc_f_reg;

    logic           tb_vld_reg  [EXP_BITS];
    erf_item_t      tb_item_reg [EXP_BITS];
    logic [6:0]     tb_n_reg    [EXP_BITS];
    logic [15:0]    tb_f_reg    [EXP_BITS];
    logic [E_W-1:0] tb_e_reg    [EXP_BITS];

    logic      out_vld_reg;
    erf_item_t out_item_reg;

    logic [33:0] sq_full;
    logic [55:0] sc_full;

    assign sq_full = 34'(in_item.mag) * 34'(in_item.mag);
    assign sc_full = 56'(sq_reg) * 56'(LOG2E_Q24) + 56'(HALF_Q24);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= 1'b0;
            sc_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg  <= in_vld;
            sc_vld_reg  <= sq_vld_reg;
            out_vld_reg <= tb_vld_reg[EXP_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_item_reg <= in_item;
            sq_reg      <= sq_full[30:0];
            sc_item_reg <= sq_item_reg;
            sc_n_reg    <= sc_full[54:48];
            sc_f_reg    <= sc_full[47:32];
        end
    end

    for (genvar j = 0; j < EXP_BITS; j++) begin : g_tab
        logic           src_vld;
        erf_item_t      src_item;
        logic [6:0]     src_n;
        logic [15:0]    src_f;
        logic [E_W-1:0] src_e;
        logic [48:0]    prod;

        if (j == 0) begin : g_first
            assign src_vld  = sc_vld_reg;
            assign src_item = sc_item_reg;
            assign src_n    = sc_n_reg;
            assign src_f    = sc_f_reg;
            assign src_e    = ONE_Q24;
        end else begin : g_next
            assign src_vld  = tb_vld_reg[j-1];
            assign src_item = tb_item_reg[j-1];
            assign src_n    = tb_n_reg[j-1];
            assign src_f    = tb_f_reg[j-1];
            assign src_e    = tb_e_reg[j-1];
        end

        assign prod = 49'(src_e) * 49'(pow2_neg_q24(4'(j))) + 49'(HALF_Q24);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tb_vld_reg[j] <= 1'b0;
            else if (en)
                tb_vld_reg[j] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tb_item_reg[j] <= src_item;
                tb_n_reg[j]    <= src_n;
                tb_f_reg[j]    <= src_f;
                tb_e_reg[j]    <= src_f[15-j] ? prod[24+E_W-1:24] : src_e;
            end
        end
    end

    logic [6:0]     fin_n;
    logic [E_W:0]   fin_rnd;
    logic [E_W:0]   fin_sum;
    logic [E_W-1:0] fin_e;
    erf_item_t      fin_item;

    always_comb
    begin
        fin_n    = tb_n_reg[EXP_BITS-1];
        fin_rnd  = (fin_n == 7'd0) ? '0 : ((E_W+1)'(1) << (fin_n - 7'd1));
        fin_sum  = {1'b0, tb_e_reg[EXP_BITS-1]} + fin_rnd;
        fin_e    = (fin_n > 7'd24) ? '0 : E_W'(fin_sum >> fin_n);
        fin_item = tb_item_reg[EXP_BITS-1];
        fin_item.e = fin_e;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_item_reg <= fin_item;
    end

    assign out_vld  = out_vld_reg;
    assign out_item = out_item_reg;

endmodule

/* tb/error_function_approx_test.sv */
module error_function_approx_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Depth of the pipeline in stages, the sum of those listed at the head of the block.
    localparam int PIPE_DEPTH    = 52;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int STALL_LIMIT   = 4000;

    // Polynomial coefficients a1..a5 and the exponential table, all in Q.24.
    localparam longint POLY_A [5] = '{64'sd4275331, -64'sd4773063, 64'sd23847365,
                                      -64'sd24379845, 64'sd17807428};
    localparam longint EXP_STEP [16] = '{
        11863283, 14107901, 15384775, 16065917, 16417715, 16596492, 16686451, 16731773,
        16754518, 16765863, 16771538, 16774377, 16775796, 16776506, 16776861, 16777039};

    // Scoreboard: computes erf for each accepted argument and holds the expected
    // values in arrival order until the matching result leaves the block.
    class erf_scoreboard;
        logic [15:0] pending_erf[$];
        int          mismatches;
        int          checked;

        // Signed Q.24 product with rounding of halves away from zero.
        static function longint scale_q24(longint v, longint t);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m * t + 64'd8388608) >>> 24;
            return (v < 0) ? -m : m;
        endfunction

        // exp(-s) in Q.24 via 2^-(s*log2 e): table walk over the fraction, then shift.
        static function longint exp_neg(longint s);
            longint u, n, f, e;
            u = (s * 64'd24204406 + 64'd8388608) >>> 24;
            n = u >>> 24;
            f = u & 64'hFFFFFF;
            e = 64'd16777216;
            for (int j = 0; j < 16; j++)
                if (f[23-j])
                    e = (e * EXP_STEP[j] + 64'd8388608) >>> 24;
            if (n > 24)
                return 0;
            if (n > 0)
                e = (e + (64'd1 << (n - 1))) >>> n;
            return e;
        endfunction

        static function logic [15:0] erf_of(logic [15:0] x);
            longint a, den, t, acc, q, e, prod, r, mag;
            a   = x[15] ? (64'h10000 - longint'(x)) : longint'(x);
            den = (64'd1 << 36) + 64'd5496067 * a;
            t   = ((64'd1 << 60) + (den >>> 1)) / den;
            acc = POLY_A[4];
            for (int k = 3; k >= 0; k--)
                acc = scale_q24(acc, t) + POLY_A[k];
            q = scale_q24(acc, t);
            if (q < 0)
                q = 0;
            e    = exp_neg(a * a);
            prod = (q * e + 64'd8388608) >>> 24;
            r    = (prod >= 64'd16777216) ? 0 : 64'd16777216 - prod;
            mag  = (r + 512) >>> 10;
            if (mag > 16384)
                mag = 16384;
            return x[15] ? 16'(-mag) : 16'(mag);
        endfunction

        function void note_argument(logic [15:0] x);
            pending_erf.push_back(erf_of(x));
        endfunction

        function void check_result(logic [15:0] got);
            logic [15:0] want;
            checked++;
            if (pending_erf.size() == 0)
            begin
                report_mismatch("result with nothing pending", 'x, got);
                return;
            end
            want = pending_erf.pop_front();
            if (got !== want)
                report_mismatch("erf_value", want, got);
        endfunction

        function void report_mismatch(string what, logic [15:0] want, logic [15:0] got);
            mismatches++;
            $display("MISMATCH %s: expected %0d got %0d at %0t", what,
                     $signed(want), $signed(got), $realtime);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    erf_scoreboard erf_board;
    bit            quiet_phase;   // in the last part of the run nobody idles
    int            idle_cycles;
    int            arguments_sent;

    error_function_approx i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Both handshakes are sampled at the edge, before the nonblocking updates land.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            erf_board.note_argument(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            erf_board.check_result(m_axis_tdata);
        if (rst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: stalls in random bursts until the quiet phase starts.
    initial
    begin
        int burst;
        m_axis_tready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 18);
                m_axis_tready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                burst = $urandom_range(1, 30);
                m_axis_tready <= 1'b1;
                repeat (burst) @(posedge clk);
            end
        end
    end

    // Presents one argument and holds it until the block takes it; a random gap
    // may be inserted before it.
    task automatic send_argument(logic [15:0] x);
        if (!quiet_phase && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        arguments_sent++;
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (erf_board.pending_erf.size() != 0)
            @(posedge clk);
    endtask

    // Half the arguments spread over the range where erf still moves, the other
    // half over the full 16-bit space.
    function automatic logic [15:0] random_argument();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(0, 16000)) - 8000);
            2:       return 16'($signed($urandom_range(0, 200)) - 100);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        logic [15:0] directed [$];
        erf_board      = new();
        quiet_phase    = 1'b0;
        idle_cycles    = 0;
        arguments_sent = 0;
        rst_n          = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero, the smallest steps, one, the extremes including the most negative
        // argument, and every single set bit so each input bit toggles.
        directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'h1000, 16'hF000, 16'h7FFF,
                     16'h8000, 16'h8001, 16'h2000, 16'hE000, 16'h0800, 16'h4000};
        for (int b = 0; b < 16; b++)
            directed.push_back(16'(1) << b);
        foreach (directed[i])
            send_argument(directed[i]);

        // Let the pipeline drain completely once before the random part.
        wait_all_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 300)
                quiet_phase = 1'b1;
            send_argument(random_argument());
        end
        wait_all_results();
        repeat (PIPE_DEPTH + 10) @(posedge clk);

        $display("Sent %0d arguments (directed extremes, every bit, random spread);", arguments_sent);
        $display("checked %0d erf results under random gaps and output stalls.", erf_board.checked);
        if (erf_board.mismatches == 0 && erf_board.pending_erf.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
